FILE: src/hms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, constants and elaboration-time helpers for the homogeneous
// medium sampler.
// ----------------------------------------------------------------------------
package hms_pkg;

   localparam int CHANNELS = 3;
   localparam int NCH_MAX  = 3;

   localparam int LN_LAT  = 18;
   localparam int EXP_LAT = 18;
   localparam int DIV_LAT = 48;
   localparam int DIV_W   = 48;
   localparam int DEN_W   = 27;
   localparam int FRAC_W  = 16;

   localparam logic [15:0] LN2_Q16   = 16'd45426;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;
   localparam logic [23:0] MAX24     = 24'hFF_FFFF;

   localparam logic [2:0] CSR_EXT0 = 3'd0;
   localparam logic [2:0] CSR_EXT1 = 3'd1;
   localparam logic [2:0] CSR_EXT2 = 3'd2;
   localparam logic [2:0] CSR_SCT0 = 3'd3;
   localparam logic [2:0] CSR_SCT1 = 3'd4;
   localparam logic [2:0] CSR_SCT2 = 3'd5;

   localparam logic [23:0] EXT_RESET = 24'd65536;
   localparam logic [23:0] SCT_RESET = 24'd32768;

   typedef struct packed {
      logic        mode;
      logic [31:0] step_limit;
      logic [23:0] dir_length;
      logic [15:0] uniform_u;
      logic [1:0]  channel_pick;
   } req_type;

   typedef struct packed {
      logic        medium_hit;
      logic [31:0] hit_step;
      logic [23:0] weight_ch0;
      logic [23:0] weight_ch1;
      logic [23:0] weight_ch2;
      logic        pdf_zero;
   } rsp_type;

   // Per-item context that travels down the pipeline beside the arithmetic.
   typedef struct packed {
      logic                      valid;
      logic                      mode;
      logic [31:0]               limit;
      logic [23:0]               len;
      logic [1:0]                ch;
      logic                      hit;
      logic [31:0]               step;
      logic [NCH_MAX-1:0][16:0]  t;
      logic                      pzero;
   } ctx_type;

   function automatic logic [63:0] hms_isqrt(input logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] b;
      a = a_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > a) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (a >= r + b) begin
               a = a - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Factor 2^(-2^-k) in Q0.32, built by repeated integer square roots.
   function automatic logic [31:0] hms_exp_factor(input int k);
      logic [63:0] g;
      g = hms_isqrt(64'h8000_0000_0000_0000);
      for (int j = 1; j < 16; j++) begin
         if (j < k) g = hms_isqrt({g[31:0], 32'h0});
      end
      return g[31:0];
   endfunction

endpackage

FILE: src/hms_ln.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_ln
// Pipelined -ln(v/65536) in Q4.16: one mantissa squaring per stage.
// ----------------------------------------------------------------------------
module hms_ln
   import hms_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [16:0] v_in,
   output logic [19:0] nl_out
);

   logic [30:0] x_ff  [FRAC_W+1];
   logic [4:0]  e_ff  [FRAC_W+1];
   logic [15:0] fr_ff [FRAC_W+1];
   logic [19:0] nl_ff;

   logic [4:0]  e0;
   logic [46:0] x0;

   always_comb begin
      e0 = '0;
      for (int i = 0; i < 17; i++) begin
         if (v_in[i]) e0 = 5'(i);
      end
      x0 = 47'(v_in) << (6'd30 - 6'(e0));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]  <= x0[30:0];
         e_ff[0]  <= e0;
         fr_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] xs;
      assign sq = 62'(x_ff[k-1]) * 62'(x_ff[k-1]);
      assign xs = sq[61:30];
      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k]  <= xs[31] ? xs[31:1] : xs[30:0];
            e_ff[k]  <= e_ff[k-1];
            fr_ff[k] <= {fr_ff[k-1][14:0], xs[31]};
         end
      end
   end

   logic [20:0] diff;
   logic [36:0] nl_prod;
   assign diff    = 21'h10_0000 - {e_ff[FRAC_W], fr_ff[FRAC_W]};
   assign nl_prod = 37'(diff) * 37'(LN2_Q16);

   always_ff @(posedge clock) begin
      if (enable) nl_ff <= nl_prod[35:16];
   end

   assign nl_out = nl_ff;

endmodule

FILE: src/hms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_div
// Pipelined restoring divider, one quotient bit per stage. A zero divisor
// gives an all-ones quotient.
// ----------------------------------------------------------------------------
module hms_div
   import hms_pkg::*;
(
   input  logic             clock,
   input  logic             enable,
   input  logic [DIV_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [DIV_W-1:0] quo_out
);

   logic [DIV_W-1:0] num_ff [DIV_W];
   logic [DIV_W-1:0] quo_ff [DIV_W];
   logic [DEN_W-1:0] rem_ff [DIV_W];
   logic [DEN_W-1:0] den_ff [DIV_W];

   for (genvar s = 0; s < DIV_W; s++) begin : g_stage
      logic [DIV_W-1:0] num_s;
      logic [DIV_W-1:0] quo_s;
      logic [DEN_W-1:0] rem_s;
      logic [DEN_W-1:0] den_s;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (s == 0) begin : g_first
         assign num_s = num_in;
         assign quo_s = '0;
         assign rem_s = '0;
         assign den_s = den_in;
      end else begin : g_next
         assign num_s = num_ff[s-1];
         assign quo_s = quo_ff[s-1];
         assign rem_s = rem_ff[s-1];
         assign den_s = den_ff[s-1];
      end

      assign trial = {rem_s, num_s[DIV_W-1]};
      assign ge    = trial >= {1'b0, den_s};
      assign diff  = trial - {1'b0, den_s};

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[s] <= {num_s[DIV_W-2:0], 1'b0};
            quo_ff[s] <= {quo_s[DIV_W-2:0], ge};
            rem_ff[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[s] <= den_s;
         end
      end
   end

   assign quo_out = quo_ff[DIV_W-1];

endmodule

FILE: src/hms_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_exp
// Pipelined exp(-tau): tau Q24.16 in, transmittance Q1.16 out, one
// fractional power-of-two factor per stage.
// ----------------------------------------------------------------------------
module hms_exp
   import hms_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [39:0] tau_in,
   output logic [16:0] t_out
);

   logic [56:0] y_prod;
   logic [40:0] y_ff;
   logic [32:0] r_ff    [FRAC_W];
   logic [15:0] f_ff    [FRAC_W];
   logic [4:0]  sh_ff   [FRAC_W];
   logic        over_ff [FRAC_W];
   logic [16:0] t_ff;

   assign y_prod = 57'(tau_in) * 57'(LOG2E_Q16);

   always_ff @(posedge clock) begin
      if (enable) y_ff <= y_prod[56:16];
   end

   for (genvar k = 0; k < FRAC_W; k++) begin : g_fac
      localparam logic [31:0] GK = hms_exp_factor(k + 1);
      logic [32:0] r_s;
      logic [15:0] f_s;
      logic [4:0]  sh_s;
      logic        over_s;
      logic [64:0] prod;

      if (k == 0) begin : g_first
         assign r_s    = 33'h1_0000_0000;
         assign f_s    = y_ff[15:0];
         assign sh_s   = y_ff[20:16];
         assign over_s = y_ff[40:16] > 25'd16;
      end else begin : g_next
         assign r_s    = r_ff[k-1];
         assign f_s    = f_ff[k-1];
         assign sh_s   = sh_ff[k-1];
         assign over_s = over_ff[k-1];
      end

      assign prod = 65'(r_s) * 65'(GK);

      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff[k]    <= f_s[FRAC_W-1-k] ? prod[64:32] : r_s;
            f_ff[k]    <= f_s;
            sh_ff[k]   <= sh_s;
            over_ff[k] <= over_s;
         end
      end
   end

   logic [33:0] rounded;
   assign rounded = 34'(r_ff[FRAC_W-1] >> sh_ff[FRAC_W-1]) + 34'h8000;

   always_ff @(posedge clock) begin
      if (enable) t_ff <= over_ff[FRAC_W-1] ? 17'd0 : rounded[32:16];
   end

   assign t_out = t_ff;

endmodule

FILE: src/homogeneous_medium_sample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_medium_sample
// Free-flight distance sampling and transmittance in a homogeneous medium.
// ----------------------------------------------------------------------------
// One ray beat enters on req_ (valid/stall) and one result beat leaves on
// rsp_ (valid/stall). Extinction and scattering coefficients are written on
// the csr_ port, index 0..2 extinction, 3..5 scattering, by the user while no
// ray is in flight, which the block does not enforce; csr_ready is always
// high and other indices are ignored. A ray is accepted in every cycle while
// req_stall is low, and its result passes through a chain of units: an
// 18-stage log, two 48-stage restoring dividers for distance and step, a
// compare stage, two multiplier stages, an 18-stage exponential, two pdf
// stages and a 48-stage weight divider, then the output register.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset is synchronous: it clears all valid bits and loads the default
// coefficients (extinction 1.0, scattering 0.5).
// ----------------------------------------------------------------------------
module homogeneous_medium_sample
   import hms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int A_IDX  = LN_LAT - 1;
   localparam int B_IDX  = A_IDX + DIV_LAT;
   localparam int C_IDX  = B_IDX + DIV_LAT;
   localparam int D_IDX  = C_IDX + 1;
   localparam int X_IDX  = D_IDX + 2 + EXP_LAT;
   localparam int Y_IDX  = X_IDX + 2 + DIV_LAT;
   localparam int CTX_DEPTH = Y_IDX + 1;

   logic [23:0] ext_ff [NCH_MAX];
   logic [23:0] sct_ff [NCH_MAX];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCH_MAX; c++) begin
            ext_ff[c] <= EXT_RESET;
            sct_ff[c] <= SCT_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXT0: ext_ff[0] <= csr_data;
            CSR_EXT1: ext_ff[1] <= csr_data;
            CSR_EXT2: ext_ff[2] <= csr_data;
            CSR_SCT0: sct_ff[0] <= csr_data;
            CSR_SCT1: sct_ff[1] <= csr_data;
            CSR_SCT2: sct_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   logic    enable;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // Negative log of 1-u.
   logic [19:0] nl;
   hms_ln u_ln (
      .clock  (clock),
      .enable (enable),
      .v_in   (17'h1_0000 - 17'(req_data.uniform_u)),
      .nl_out (nl)
   );

   ctx_type ctx_ff [CTX_DEPTH];
   ctx_type ctx_in [CTX_DEPTH];

   // Distance along the ray, then parametric step.
   logic [DIV_W-1:0] d1_quo;
   logic [DIV_W-1:0] d2_quo;
   logic [31:0]      flight_len;
   logic [31:0]      s_step;

   hms_div u_div_dist (
      .clock   (clock),
      .enable  (enable),
      .num_in  ({12'h0, nl, 16'h0}),
      .den_in  (DEN_W'(ext_ff[ctx_ff[A_IDX].ch])),
      .quo_out (d1_quo)
   );

   assign flight_len = (|d1_quo[DIV_W-1:32]) ? MAX32 : d1_quo[31:0];

   hms_div u_div_step (
      .clock   (clock),
      .enable  (enable),
      .num_in  ({flight_len, 16'h0}),
      .den_in  (DEN_W'(ctx_ff[B_IDX].len)),
      .quo_out (d2_quo)
   );

   assign s_step = (|d2_quo[DIV_W-1:32]) ? MAX32 : d2_quo[31:0];

   // Optical depth per channel.
   logic [55:0] prod_ff;
   logic [31:0] path;
   logic [39:0] tau_ff [NCH_MAX];

   assign path = (|prod_ff[55:48]) ? MAX32 : prod_ff[47:16];

   always_ff @(posedge clock) begin
      if (enable) prod_ff <= 56'(ctx_ff[D_IDX].step) * 56'(ctx_ff[D_IDX].len);
   end

   logic [16:0] t_ch   [NCH_MAX];
   logic [23:0] p_ff   [NCH_MAX];
   logic [40:0] n_ff   [NCH_MAX];
   logic [42:0] num3_ff[NCH_MAX];
   logic [25:0] sum_ff;
   logic [25:0] sum_c;
   logic [DIV_W-1:0] w_quo [NCH_MAX];

   for (genvar c = 0; c < NCH_MAX; c++) begin : g_ch
      logic [55:0] tau_prod;
      logic [40:0] pe_prod;

      assign tau_prod = 56'(ext_ff[c]) * 56'(path);
      assign pe_prod  = 41'(ext_ff[c]) * 41'(t_ch[c]);

      always_ff @(posedge clock) begin
         if (enable) begin
            tau_ff[c]  <= tau_prod[55:16];
            p_ff[c]    <= ctx_ff[X_IDX].hit ? pe_prod[39:16] : 24'(t_ch[c]);
            n_ff[c]    <= ctx_ff[X_IDX].hit ? 41'(t_ch[c]) * 41'(sct_ff[c])
                                            : 41'({t_ch[c], 16'h0});
            num3_ff[c] <= 43'(n_ff[c]) * 43'(CHANNELS);
         end
      end

      hms_exp u_exp (
         .clock  (clock),
         .enable (enable),
         .tau_in (tau_ff[c]),
         .t_out  (t_ch[c])
      );

      hms_div u_div_weight (
         .clock   (clock),
         .enable  (enable),
         .num_in  (DIV_W'(num3_ff[c])),
         .den_in  (DEN_W'(sum_ff)),
         .quo_out (w_quo[c])
      );
   end

   // Only the active channels contribute to the averaged pdf.
   always_comb begin
      sum_c = '0;
      for (int c = 0; c < NCH_MAX; c++) begin
         if (c < CHANNELS) sum_c = sum_c + 26'(p_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) sum_ff <= sum_c;
   end

   always_comb begin
      ctx_in[0].valid = req_valid && !req_stall;
      ctx_in[0].mode  = req_data.mode;
      ctx_in[0].limit = req_data.step_limit;
      ctx_in[0].len   = req_data.dir_length;
      ctx_in[0].ch    = (req_data.channel_pick > 2'(CHANNELS - 1)) ?
                        2'(CHANNELS - 1) : req_data.channel_pick;
      ctx_in[0].hit   = 1'b0;
      ctx_in[0].step  = '0;
      ctx_in[0].t     = '0;
      ctx_in[0].pzero = 1'b0;
      for (int i = 1; i < CTX_DEPTH; i++) ctx_in[i] = ctx_ff[i-1];

      ctx_in[D_IDX].hit  = !ctx_ff[C_IDX].mode && (s_step < ctx_ff[C_IDX].limit);
      ctx_in[D_IDX].step = ctx_in[D_IDX].hit ? s_step : ctx_ff[C_IDX].limit;

      for (int c = 0; c < NCH_MAX; c++) ctx_in[X_IDX+1].t[c] = t_ch[c];
      ctx_in[X_IDX+2].pzero = (sum_c == 26'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CTX_DEPTH; i++) ctx_ff[i].valid <= 1'b0;
      end else if (enable) begin
         for (int i = 0; i < CTX_DEPTH; i++) ctx_ff[i] <= ctx_in[i];
      end
   end

   logic [NCH_MAX-1:0][23:0] w_out;

   always_comb begin
      for (int c = 0; c < NCH_MAX; c++) begin
         if (c >= CHANNELS) w_out[c] = '0;
         else if (ctx_ff[Y_IDX].mode) w_out[c] = 24'(ctx_ff[Y_IDX].t[c]);
         else if (ctx_ff[Y_IDX].pzero) w_out[c] = '0;
         else w_out[c] = (|w_quo[c][DIV_W-1:24]) ? MAX24 : w_quo[c][23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= ctx_ff[Y_IDX].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff.medium_hit <= ctx_ff[Y_IDX].hit;
         rsp_ff.hit_step   <= ctx_ff[Y_IDX].step;
         rsp_ff.weight_ch0 <= w_out[0];
         rsp_ff.weight_ch1 <= w_out[1];
         rsp_ff.weight_ch2 <= w_out[2];
         rsp_ff.pdf_zero   <= ctx_ff[Y_IDX].pzero && !ctx_ff[Y_IDX].mode;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The input side only backs off while a finished result is held.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled without a held result");

   // A zero pdf forces every weight to zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pdf_zero) |->
      (rsp_data.weight_ch0 == 24'd0 && rsp_data.weight_ch1 == 24'd0 &&
       rsp_data.weight_ch2 == 24'd0))
      else $error("weights not cleared on zero pdf");

   // A held result freezes the last pipeline stage.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(ctx_ff[Y_IDX]))
      else $error("pipeline moved during a stall");

   // A medium event always lies before the step limit.
   assert property (@(posedge clock) disable iff (reset)
      ctx_ff[D_IDX].valid && ctx_ff[D_IDX].hit |->
      (ctx_ff[D_IDX].step < ctx_ff[D_IDX].limit && !ctx_ff[D_IDX].mode))
      else $error("hit step not below limit");

endmodule
